### hw/rtl/dsem_pkg.sv
// Package for the depth scanline edge mask.
// Holds the configuration register indexes, their widths and reset values, and the config struct.
// No dependencies.
package dsem_pkg;

    localparam int COUNT_BITS     = 10;
    localparam int THRESH_BITS    = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE            = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RUN_LENGTH      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EDGE_THRESHOLD  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EMPTY_THRESHOLD = 2'd3;

    localparam logic                   MODE_EDGE  = 1'b0;
    localparam logic                   MODE_BEVEL = 1'b1;

    localparam logic [COUNT_BITS-1:0]  RUN_LENGTH_RESET      = 10'd8;
    localparam logic [THRESH_BITS-1:0] EDGE_THRESHOLD_RESET  = 16'd100;
    localparam logic [THRESH_BITS-1:0] EMPTY_THRESHOLD_RESET = 16'd1;

    typedef struct packed {
        logic                   mode;
        logic [COUNT_BITS-1:0]  run_length;
        logic [THRESH_BITS-1:0] edge_threshold;
        logic [THRESH_BITS-1:0] empty_threshold;
    } cfg_t;

endpackage

### hw/rtl/dsem_cfg_regs.sv
// Configuration register file of the depth scanline edge mask.
// Depends on dsem_pkg for the register indexes, widths and reset values.
module dsem_cfg_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [dsem_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [dsem_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output dsem_pkg::cfg_t                        cfg
);
    import dsem_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:            cfg_next.mode            = cfg_data[0];
                CFG_RUN_LENGTH:      cfg_next.run_length      = cfg_data[COUNT_BITS-1:0];
                CFG_EDGE_THRESHOLD:  cfg_next.edge_threshold  = cfg_data[THRESH_BITS-1:0];
                CFG_EMPTY_THRESHOLD: cfg_next.empty_threshold = cfg_data[THRESH_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode            <= MODE_EDGE;
            cfg_reg.run_length      <= RUN_LENGTH_RESET;
            cfg_reg.edge_threshold  <= EDGE_THRESHOLD_RESET;
            cfg_reg.empty_threshold <= EMPTY_THRESHOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/dsem_mask_core.sv
// Mask decision and scan state (previous depth and countdown) of the depth scanline edge mask.
// Depends on dsem_pkg for the config struct and widths.
module dsem_mask_core #(
    parameter int DEPTH_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dsem_pkg::cfg_t        cfg,
    input  logic                  fire,
    input  logic [DEPTH_BITS-1:0] depth,
    input  logic                  start,
    output logic                  mask
);
    import dsem_pkg::*;

    localparam int CMP_BITS = (DEPTH_BITS > THRESH_BITS) ? DEPTH_BITS : THRESH_BITS;

    logic [DEPTH_BITS-1:0] prev_depth_reg;
    logic [DEPTH_BITS-1:0] prev_depth_next;
    logic [COUNT_BITS-1:0] countdown_reg;
    logic [COUNT_BITS-1:0] countdown_next;

    logic [DEPTH_BITS-1:0] prev_eff;
    logic [COUNT_BITS-1:0] count_eff;
    logic [DEPTH_BITS-1:0] diff;
    logic                  edge_hit;
    logic                  empty_hit;
    logic                  trigger;

    always_comb
    begin
        prev_eff  = start ? '0 : prev_depth_reg;
        count_eff = start ? '0 : countdown_reg;
        diff      = (depth > prev_eff) ? (depth - prev_eff) : (prev_eff - depth);
        edge_hit  = (depth != '0) && (prev_eff != '0)
                    && (CMP_BITS'(diff) > CMP_BITS'(cfg.edge_threshold));
        empty_hit = CMP_BITS'(depth) < CMP_BITS'(cfg.empty_threshold);
        trigger   = (cfg.mode == MODE_BEVEL) ? empty_hit : edge_hit;
        mask      = (count_eff != '0);

        if (count_eff != '0)
        begin
            countdown_next = count_eff - COUNT_BITS'(1);
        end
        else if (trigger)
        begin
            countdown_next = cfg.run_length;
        end
        else
        begin
            countdown_next = '0;
        end
        prev_depth_next = depth;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_depth_reg <= '0;
            countdown_reg  <= '0;
        end
        else if (fire)
        begin
            prev_depth_reg <= prev_depth_next;
            countdown_reg  <= countdown_next;
        end
    end

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && start) |=> (countdown_reg == '0 || countdown_reg == $past(cfg.run_length)))
        else $error("countdown after a line start is neither zero nor the run length");

    a_count_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !start && countdown_reg != '0)
        |=> (countdown_reg == $past(countdown_reg) - COUNT_BITS'(1)))
        else $error("running countdown did not decrement by one");

    a_empty_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !start && countdown_reg == '0 && cfg.mode == MODE_BEVEL
         && CMP_BITS'(depth) < CMP_BITS'(cfg.empty_threshold))
        |=> (countdown_reg == $past(cfg.run_length)))
        else $error("empty sample in bevel mode did not load the run length");

endmodule

### hw/rtl/depth_scanline_edge_mask.sv
// Depth scanline edge mask: flags samples after depth jumps or empty samples along a scan line.
// An accepted sample is registered in stage 1, then its mask result in the output register.
// Throughput: one sample per cycle unless out_ready stalls; countdown and previous depth update per sample.
// Reset (asynchronous, active low) empties both pipeline registers, clears the scan state and
// loads the configuration defaults: edge mode, run length 8, edge threshold 100, empty threshold 1.
// Depends on dsem_pkg, dsem_cfg_regs and dsem_mask_core.
module depth_scanline_edge_mask #(
    parameter int DEPTH_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dsem_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dsem_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [DEPTH_BITS-1:0]                depth_sample,
    input  logic                                 line_start,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 masked
);
    import dsem_pkg::*;

    cfg_t                  cfg;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [DEPTH_BITS-1:0] s1_depth_reg;
    logic                  s1_start_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  masked_reg;
    logic                  mask;
    logic                  advance;
    logic                  in_fire;

    dsem_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dsem_mask_core #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_mask_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (advance),
        .depth (s1_depth_reg),
        .start (s1_start_reg),
        .mask  (mask)
    );

    always_comb
    begin
        advance  = s1_valid_reg && (!out_valid_reg || out_ready);
        in_ready = !s1_valid_reg || advance;
        in_fire  = in_valid && in_ready;

        s1_valid_next = in_fire || (s1_valid_reg && !advance);

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_depth_reg <= depth_sample;
            s1_start_reg <= line_start;
        end
        if (advance)
        begin
            masked_reg <= mask;
        end
    end

    assign out_valid = out_valid_reg;
    assign masked    = masked_reg;

endmodule
